// ===== hdl/bdsu_pkg.sv =====
// Shared types and constants for the braking distance / safe speed unit.
package bdsu_pkg;

  localparam int unsigned HORNER_CELLS = 4;
  localparam int unsigned ROOT_CELLS   = 35;  // quotient bits of the distance divide
  localparam int unsigned SQRT_STEPS   = 27;  // root bits of the safe-speed isqrt

  localparam logic [28:0] ONE_Q28     = 29'h1000_0000;
  localparam logic [15:0] HALF_PI_Q14 = 16'd25736;
  localparam logic [16:0] PI_Q14      = 17'd51472;
  localparam logic [23:0] DIST_MAX    = 24'hFF_FFFF;
  localparam logic [15:0] SPEED_MAX   = 16'hFFFF;
  localparam logic [15:0] SPEED_FLOOR = 16'd26;

  // Horner divisors and floor(2^32 / d) reciprocals
  localparam logic [6:0]  HORNER_DIV [HORNER_CELLS] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [31:0] RECIP_72 = 32'((64'd1 << 32) / 72);
  localparam logic [31:0] RECIP_42 = 32'((64'd1 << 32) / 42);
  localparam logic [31:0] RECIP_20 = 32'((64'd1 << 32) / 20);
  localparam logic [31:0] RECIP_6  = 32'((64'd1 << 32) / 6);
  localparam logic [31:0] RECIP_5  = 32'((64'd1 << 32) / 5);
  localparam logic [31:0] HORNER_RECIP [HORNER_CELLS] =
    '{RECIP_72, RECIP_42, RECIP_20, RECIP_6};

  // Configuration register indexes
  localparam logic [1:0] REG_REACTION = 2'd0;
  localparam logic [1:0] REG_FRICTION = 2'd1;

  // Sine series pipeline word
  typedef struct packed {
    logic        valid;
    logic        func;
    logic [15:0] vmag;
    logic [23:0] avail_dist;
    logic [14:0] x;
    logic [29:0] x2;
    logic [28:0] t;
  } horner_t;

  // Divide / square-root chain word
  typedef struct packed {
    logic        valid;
    logic        func;
    logic        nob;
    logic        sat;
    logic [31:0] divisor;
    logic [26:0] rv;
    logic [20:0] ar;
    logic [31:0] rem;
    logic [34:0] acc;
    logic [53:0] bits;
  } root_t;

endpackage

// ===== hdl/braking_distance_speed_unit_top.sv =====
// Braking envelope unit top: stopping distance or safe speed from pitch and friction.
//
//  channel  | handshake          | content (low bit first)
//  ---------+--------------------+---------------------------------------------
//  s_*      | s_tvalid/s_tready  | tdata: speed[15:0] pitch[31:16] distance[55:32]
//           |                    | tuser: func
//  m_*      | m_tvalid/m_tready  | tdata: stopping_distance[23:0] safe_speed[39:24]
//           |                    | tuser: no_braking
//  cfg_*    | cfg_valid/cfg_ready| cfg_index 0 reaction_time, 1 braking_friction
//
// One request per clock while the output is not stalled, fully pipelined. The pipe is
// made of the 35-cell divide/isqrt chain, the 4 three-stage sine series cells,
// the S, N, A, M and Q arithmetic stages and the output register.
// The whole pipe advances unless the output register holds an untaken result.
// rst is synchronous: it clears valids and loads the register defaults.
// Config writes are always taken (cfg_ready is tied high).
module braking_distance_speed_unit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // speed[15:0], pitch[31:16], distance[55:32]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // stopping_distance[23:0], safe_speed[39:24]
  output logic        m_tuser,   // no_braking
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int unsigned NH = bdsu_pkg::HORNER_CELLS;
  localparam int unsigned NR = bdsu_pkg::ROOT_CELLS;

  logic        adv;
  logic [10:0] reaction_time;
  logic [9:0]  braking_friction;

  // ---- config ----
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reaction_time    <= 11'd410;
      braking_friction <= 10'd205;
    end else if (cfg_valid) begin
      case (cfg_index)
        bdsu_pkg::REG_REACTION: reaction_time    <= cfg_data;
        bdsu_pkg::REG_FRICTION: braking_friction <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // ---- input decode: |speed|, clamped and folded pitch, x^2 ----
  logic [15:0] speed;
  logic [15:0] pitch;
  logic [15:0] xm;
  logic [14:0] xf;
  bdsu_pkg::horner_t h_in;

  assign speed = s_tdata[15:0];
  assign pitch = s_tdata[31:16];
  assign xm    = pitch[15] ? 16'(16'd0 - pitch) : 16'd0;
  assign xf    = (xm > bdsu_pkg::HALF_PI_Q14) ? 15'(bdsu_pkg::PI_Q14 - {1'b0, xm})
                                             : xm[14:0];

  always_comb begin
    h_in.valid      = s_tvalid;
    h_in.func       = s_tuser;
    h_in.vmag       = speed[15] ? 16'(16'd0 - speed) : speed;
    h_in.avail_dist = s_tdata[55:32];
    h_in.x          = xf;
    h_in.x2         = 30'(xf) * 30'(xf);
    h_in.t          = bdsu_pkg::ONE_Q28;
  end

  // ---- sine series cells ----
  bdsu_pkg::horner_t hc [NH+1];
  assign hc[0] = h_in;

  for (genvar i = 0; i < NH; i++) begin : g_horner
    bdsu_horner_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .divisor (bdsu_pkg::HORNER_DIV[i]),
      .recip   (bdsu_pkg::HORNER_RECIP[i]),
      .din     (hc[i]),
      .dout    (hc[i+1])
    );
  end

  // ---- S: sin = x * t >> 14 ----
  logic        vs, func_s;
  logic [15:0] vmag_s;
  logic [23:0] dist_s;
  logic [28:0] sin_s;
  logic [43:0] sin_prod;
  assign sin_prod = 44'(hc[NH].x) * 44'(hc[NH].t);

  // ---- N: friction minus sine, reciprocal estimate of 4*sum/5 ----
  logic        vn, func_n, nob_n;
  logic [15:0] vmag_n;
  logic [23:0] dist_n;
  logic [27:0] sum_n;
  logic [27:0] q0_n;
  logic [27:0] fq;
  logic [27:0] sum_n_c;
  logic [61:0] q5_prod;
  assign fq      = {braking_friction, 18'b0};
  assign sum_n_c = 28'(29'(fq) - sin_s);
  assign q5_prod = 62'({sum_n_c, 2'b00}) * 62'(bdsu_pkg::RECIP_5);

  // ---- A: deceleration A = 9*sum + floor(4*sum/5), up to 32 bits ----
  logic        va, func_a, nob_a;
  logic [15:0] vmag_a;
  logic [23:0] dist_a;
  logic [31:0] a_a;
  logic [29:0] r5;
  logic        c5;
  assign r5 = {sum_n, 2'b00} - 30'(31'(q0_n) * 31'(3'd5));
  assign c5 = r5 >= 30'd5;

  // ---- M: products ----
  logic        vm, func_m, nob_m;
  logic [31:0] a_m;
  logic [26:0] rv_m;
  logic [30:0] vsq_m;
  logic [20:0] ar_m;
  logic [52:0] ad3_m;
  logic [42:0] ar_prod;
  logic [55:0] ad_prod;
  assign ar_prod = 43'(a_a) * 43'(reaction_time);
  assign ad_prod = 56'(a_a) * 56'(dist_a);

  // ---- Q: radicand S = AR^2 + (A*d >> 3) ----
  logic        vq, func_q, nob_q;
  logic [31:0] a_q;
  logic [26:0] rv_q;
  logic [30:0] vsq_q;
  logic [20:0] ar_q;
  logic [52:0] sq_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
      vn <= 1'b0;
      va <= 1'b0;
      vm <= 1'b0;
      vq <= 1'b0;
    end else if (adv) begin
      vs <= hc[NH].valid;
      vn <= vs;
      va <= vn;
      vm <= va;
      vq <= vm;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func_s <= hc[NH].func;
      vmag_s <= hc[NH].vmag;
      dist_s <= hc[NH].avail_dist;
      sin_s  <= sin_prod[42:14];

      func_n <= func_s;
      vmag_n <= vmag_s;
      dist_n <= dist_s;
      nob_n  <= 29'(fq) <= sin_s;
      sum_n  <= sum_n_c;
      q0_n   <= q5_prod[59:32];

      func_a <= func_n;
      vmag_a <= vmag_n;
      dist_a <= dist_n;
      nob_a  <= nob_n;
      a_a    <= nob_n ? 32'd0
                      : 32'(32'(sum_n) * 32'(4'd9)) + 32'(q0_n) + 32'(c5);

      func_m <= func_a;
      nob_m  <= nob_a;
      a_m    <= a_a;
      rv_m   <= 27'(reaction_time) * 27'(vmag_a);
      vsq_m  <= 31'(vmag_a) * 31'(vmag_a);
      ar_m   <= ar_prod[42:22];
      ad3_m  <= ad_prod[55:3];

      func_q <= func_m;
      nob_q  <= nob_m;
      a_q    <= a_m;
      rv_q   <= rv_m;
      vsq_q  <= vsq_m;
      ar_q   <= ar_m;
      sq_q   <= 53'(42'(ar_m) * 42'(ar_m)) + ad3_m;
    end
  end

  // ---- divide / isqrt chain ----
  // func 0: quotient of (v^2 << 29) / A, 35 bits; overflow flagged up front.
  // func 1: floor sqrt of S over the first SQRT_STEPS cells.
  bdsu_pkg::root_t rc [NR+1];

  always_comb begin
    rc[0].valid   = vq;
    rc[0].func    = func_q;
    rc[0].nob     = nob_q;
    rc[0].sat     = !func_q && (32'(vsq_q[30:6]) >= a_q);
    rc[0].divisor = a_q;
    rc[0].rv      = rv_q;
    rc[0].ar      = ar_q;
    rc[0].rem     = func_q ? 32'd0 : 32'(vsq_q[30:6]);
    rc[0].acc     = '0;
    rc[0].bits    = func_q ? {1'b0, sq_q} : {vsq_q[5:0], 48'b0};
  end

  for (genvar j = 0; j < NR; j++) begin : g_root
    bdsu_root_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .adv     (adv),
      .sqrt_on (j < bdsu_pkg::SQRT_STEPS),
      .din     (rc[j]),
      .dout    (rc[j+1])
    );
  end

  // ---- result formatting ----
  logic [35:0] total;
  logic [25:0] d_rnd;
  logic [23:0] dist_out;
  logic [26:0] root;
  logic [26:0] v_diff;
  logic [27:0] v_sum;
  logic [19:0] v_rnd;
  logic [15:0] speed_out;

  always_comb begin
    total = 36'(rc[NR].rv) + 36'(rc[NR].acc) + 36'd512;
    d_rnd = total[35:10];
    if (rc[NR].nob || rc[NR].sat || (d_rnd[25:24] != 2'b00)) begin
      dist_out = bdsu_pkg::DIST_MAX;
    end else begin
      dist_out = d_rnd[23:0];
    end

    root   = rc[NR].acc[26:0];
    v_diff = (root > 27'(rc[NR].ar)) ? root - 27'(rc[NR].ar) : 27'd0;
    v_sum  = 28'(v_diff) + 28'd128;
    v_rnd  = v_sum[27:8];
    if (rc[NR].nob || (v_rnd < 20'(bdsu_pkg::SPEED_FLOOR))) begin
      speed_out = bdsu_pkg::SPEED_FLOOR;
    end else if (v_rnd > 20'(bdsu_pkg::SPEED_MAX)) begin
      speed_out = bdsu_pkg::SPEED_MAX;
    end else begin
      speed_out = v_rnd[15:0];
    end
  end

  // output register; holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= rc[NR].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata[23:0]  <= rc[NR].func ? 24'd0 : dist_out;
      m_tdata[39:24] <= rc[NR].func ? speed_out : 16'd0;
      m_tuser        <= rc[NR].nob;
    end
  end

endmodule

// ===== hdl/bdsu_horner_cell.sv =====
// One Horner step of the sine series: t' = 1 - ((x2 * t) >> 28) / d, three stages.
module bdsu_horner_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic [6:0]        divisor,
  input  logic [31:0]       recip,
  input  bdsu_pkg::horner_t din,
  output bdsu_pkg::horner_t dout
);

  bdsu_pkg::horner_t sa;
  bdsu_pkg::horner_t sb;
  bdsu_pkg::horner_t sb_out;
  logic [58:0] mul_a;
  logic [29:0] p_q;
  logic [29:0] p_r;
  logic [61:0] mul_b;
  logic [27:0] q0_q;
  logic [29:0] rem_c;
  logic        corr;
  logic [28:0] t_c;

  assign mul_a = 59'(din.x2) * 59'(din.t);
  assign mul_b = 62'(p_q) * 62'(recip);
  // reciprocal estimate is low by at most one
  assign rem_c = p_r - 30'(35'(q0_q) * 35'(divisor));
  assign corr  = rem_c >= 30'(divisor);
  assign t_c   = bdsu_pkg::ONE_Q28 - 29'(q0_q) - 29'(corr);

  always_comb begin
    sb_out   = sb;
    sb_out.t = t_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sa.valid   <= 1'b0;
      sb.valid   <= 1'b0;
      dout.valid <= 1'b0;
    end else if (adv) begin
      sa   <= din;
      p_q  <= mul_a[57:28];
      sb   <= sa;
      p_r  <= p_q;
      q0_q <= mul_b[59:32];
      dout <= sb_out;
    end
  end

endmodule

// ===== hdl/bdsu_root_cell.sv =====
// One restoring step shared by the distance divide (1 bit) and the isqrt (2 bits).
module bdsu_root_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            sqrt_on,
  input  bdsu_pkg::root_t din,
  output bdsu_pkg::root_t dout
);

  logic [33:0] rem_sh;
  logic [33:0] trial;
  logic [33:0] rem_sub;
  logic        take;
  logic        step;
  bdsu_pkg::root_t nxt;

  always_comb begin
    if (din.func) begin
      rem_sh = {din.rem, din.bits[53:52]};
      trial  = {5'b0, din.acc[26:0], 2'b01};
    end else begin
      rem_sh = {1'b0, din.rem, din.bits[53]};
      trial  = {2'b0, din.divisor};
    end
    take    = rem_sh >= trial;
    rem_sub = rem_sh - trial;
    step    = !din.func || sqrt_on;
    nxt     = din;
    if (step) begin
      nxt.rem  = take ? rem_sub[31:0] : rem_sh[31:0];
      nxt.acc  = {din.acc[33:0], take};
      nxt.bits = din.func ? {din.bits[51:0], 2'b00} : {din.bits[52:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout <= nxt;
    end
  end

endmodule

// ===== hdl/bdsu_checker.sv =====
// Port-level checks for the braking envelope unit, bound to the top level.
module bdsu_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tuser
);

  // stalled result stays offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // reset empties the pipe
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result after reset");

  // at most one of the two results is nonzero
  a_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[23:0] != 24'd0) |-> m_tdata[39:24] == 16'd0)
    else $error("both result fields set");

  // a safe speed never drops below the floor
  a_floor: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[39:24] != 16'd0) |-> m_tdata[39:24] >= 16'd26)
    else $error("safe speed below floor");

  // no braking: saturated distance or floor speed
  a_nob: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |->
      (m_tdata[23:0] == 24'hFF_FFFF) || (m_tdata[39:24] == 16'd26))
    else $error("bad no-braking result");

endmodule

bind braking_distance_speed_unit_top bdsu_checker u_bdsu_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== verif/braking_distance_speed_unit_top_tb.sv =====
// Testbench for the braking envelope unit: stream stimulus, built-in predictor, scoreboard.
module braking_distance_speed_unit_top_tb;

  localparam logic FUNC_DISTANCE   = 1'b0;
  localparam logic FUNC_SAFE_SPEED = 1'b1;
  localparam logic [1:0] REG_SPARE_LO = 2'd2;  // unmapped, writes dropped
  localparam logic [1:0] REG_SPARE_HI = 2'd3;
  localparam int unsigned PIPE_DEPTH = 53;

  typedef struct packed {
    logic        nb;
    logic [15:0] safe_speed;
    logic [23:0] stop_dist;
  } envelope_t;

  // Expected-result store plus an independent copy of the register file.
  class braking_scoreboard;
    logic [10:0] react;
    logic [9:0]  fric;
    envelope_t   pending_q[$];
    int          errors;
    int          checked;
    int          nobrake_seen;

    function new();
      react = 11'd410;
      fric  = 10'd205;
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] val);
      if (idx == bdsu_pkg::REG_REACTION) react = val;
      else if (idx == bdsu_pkg::REG_FRICTION) fric = val[9:0];
    endfunction

    function logic [63:0] root64(logic [63:0] n);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n   = n - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    // Truncating Horner sine, Q14 in, Q28 out
    function logic [63:0] sine_q28(logic [63:0] x);
      logic [63:0] xq, x2, t;
      if (x > bdsu_pkg::HALF_PI_Q14) x = bdsu_pkg::PI_Q14 - x;
      xq = x << 14;
      x2 = (xq * xq) >> 28;
      t = bdsu_pkg::ONE_Q28 - x2 / 72;
      t = bdsu_pkg::ONE_Q28 - ((x2 * t) >> 28) / 42;
      t = bdsu_pkg::ONE_Q28 - ((x2 * t) >> 28) / 20;
      t = bdsu_pkg::ONE_Q28 - ((x2 * t) >> 28) / 6;
      return (xq * t) >> 28;
    endfunction

    function envelope_t predict_envelope(logic func, logic [15:0] spd, logic [15:0] pit,
                                         logic [23:0] avail_dist);
      envelope_t   e;
      logic [63:0] vmag, x, s, fq, a, total, d, ar, sq, rt, v;
      logic        nob;
      vmag = spd[15] ? 64'h10000 - spd : spd;
      x    = pit[15] ? 64'h10000 - pit : 0;   // nose-up pitch clamps to level
      s    = sine_q28(x);
      fq   = 64'(fric) << 18;
      nob  = (fq <= s);
      a    = nob ? 0 : ((fq - s) * 49) / 5;
      e = '0;
      e.nb = nob;
      if (func == FUNC_DISTANCE) begin
        if (nob || a == 0) begin
          e.stop_dist = bdsu_pkg::DIST_MAX;
        end else begin
          total = 64'(react) * vmag + ((vmag * vmag) << 29) / a;
          d = (total + 512) >> 10;
          e.stop_dist = (d > bdsu_pkg::DIST_MAX) ? bdsu_pkg::DIST_MAX : d[23:0];
        end
      end else if (nob) begin
        e.safe_speed = bdsu_pkg::SPEED_FLOOR;
      end else begin
        ar = (a * react) >> 22;
        sq = ar * ar + ((a * avail_dist) >> 3);
        rt = root64(sq);
        v  = (rt > ar) ? rt - ar : 0;
        v  = (v + 128) >> 8;
        if (v < bdsu_pkg::SPEED_FLOOR) v = bdsu_pkg::SPEED_FLOOR;
        if (v > bdsu_pkg::SPEED_MAX) v = bdsu_pkg::SPEED_MAX;
        e.safe_speed = v[15:0];
      end
      return e;
    endfunction

    function void note_request(logic func, logic [15:0] spd, logic [15:0] pit,
                               logic [23:0] avail_dist);
      pending_q.push_back(predict_envelope(func, spd, pit, avail_dist));
    endfunction

    function void check_result(logic [39:0] data, logic nb);
      envelope_t e;
      if (pending_q.size() == 0) begin
        $error("result with nothing outstanding: tdata=%h tuser=%b", data, nb);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (e.nb) nobrake_seen++;
      if (data[23:0] !== e.stop_dist) begin
        $error("stopping_distance exp %0d got %0d", e.stop_dist, data[23:0]);
        errors++;
      end
      if (data[39:24] !== e.safe_speed) begin
        $error("safe_speed exp %0d got %0d", e.safe_speed, data[39:24]);
        errors++;
      end
      if (nb !== e.nb) begin
        $error("no_braking exp %0b got %0b", e.nb, nb);
        errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready, s_tuser;
  logic [55:0] s_tdata;
  logic        m_tvalid, m_tready, m_tuser;
  logic [39:0] m_tdata;
  logic        cfg_valid, cfg_ready;
  logic [1:0]  cfg_index;
  logic [10:0] cfg_data;

  braking_scoreboard sb;
  bit idle_on;        // random gaps on both sides
  int hold_cycles;    // receiver back-pressure stretch, counted down below
  int sent;

  braking_distance_speed_unit_top i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Receiver: check on every taken result, then pick next-cycle ready.
  initial begin
    m_tready = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(idle_on && $urandom_range(99) < 28);
      end
    end
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #4000000;
    $display("braking_distance_speed_unit_top verification failed");
    $finish;
  end

  task automatic send_request(logic func, logic [15:0] spd, logic [15:0] pit,
                              logic [23:0] avail_dist);
    while (idle_on && $urandom_range(99) < 28) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {avail_dist, pit, spd};
    do @(posedge clk); while (!s_tready);
    sb.note_request(func, spd, pit, avail_dist);
    sent++;
  endtask

  // Registers change only with the pipe drained.
  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_requests(int n);
    logic [15:0] spd, pit;
    logic [23:0] avail_dist;
    int          k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      spd = (k < 80) ? 16'($signed($urandom_range(51200)) - 25600) : 16'($urandom);
      k = $urandom_range(99);
      if (k < 50)      pit = 16'(-$signed($urandom_range(25736)));
      else if (k < 70) pit = 16'($urandom_range(32767));
      else             pit = 16'($urandom);
      avail_dist = ($urandom_range(1)) ? 24'($urandom_range(65535)) : 24'($urandom);
      send_request(1'($urandom_range(1)), spd, pit, avail_dist);
    end
  endtask

  initial begin
    sb = new();
    rst = 1; s_tvalid = 0; s_tuser = 0; s_tdata = '0;
    cfg_valid = 0; cfg_index = '0; cfg_data = '0;
    idle_on = 0; hold_cycles = 0; sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes under reset registers, both functions.
    send_request(FUNC_DISTANCE,   16'd0,      16'd0,      24'd0);
    send_request(FUNC_DISTANCE,   16'd25600,  16'd0,      24'd0);
    send_request(FUNC_DISTANCE,   -16'sd25600, 16'd0,     24'd0);
    send_request(FUNC_DISTANCE,   16'h8000,   16'h8000,   24'hFFFFFF);
    send_request(FUNC_DISTANCE,   16'h7FFF,   16'h7FFF,   24'd0);
    send_request(FUNC_DISTANCE,   16'd2560,   -16'sd25736, 24'd0); // downhill, no braking
    send_request(FUNC_DISTANCE,   16'd2560,   -16'sd32768, 24'd0); // -2 rad, folded
    send_request(FUNC_DISTANCE,   16'd2560,   -16'sd3300, 24'd0);  // near friction limit
    send_request(FUNC_DISTANCE,   16'd2560,   -16'sd3400, 24'd0);
    send_request(FUNC_SAFE_SPEED, 16'd0,      16'd0,      24'd0);  // floor speed
    send_request(FUNC_SAFE_SPEED, 16'd0,      16'd0,      24'hFFFFFF);
    send_request(FUNC_SAFE_SPEED, 16'hFFFF,   16'd100,    24'd256);
    send_request(FUNC_SAFE_SPEED, 16'd0,      -16'sd25736, 24'd5000); // no braking
    send_request(FUNC_SAFE_SPEED, 16'd0,      -16'sd32768, 24'd5000);
    send_request(FUNC_SAFE_SPEED, 16'd0,      -16'sd1,    24'd1);
    send_request(FUNC_SAFE_SPEED, 16'd0,      16'h8001,   24'h800000);

    // Register sweep: reset values, extremes, ignored indexes.
    idle_on = 1;
    random_requests(60);
    write_reg(bdsu_pkg::REG_REACTION, 11'd102);
    write_reg(bdsu_pkg::REG_FRICTION, 11'd102);
    random_requests(60);
    write_reg(bdsu_pkg::REG_REACTION, 11'd1024);
    write_reg(bdsu_pkg::REG_FRICTION, 11'd768);
    write_reg(REG_SPARE_LO, 11'h7FF);
    write_reg(REG_SPARE_HI, 11'h000);
    hold_cycles = 300;  // long output stall: pipe fills, input must back up
    random_requests(80);
    write_reg(bdsu_pkg::REG_REACTION, 11'h7FF);
    write_reg(bdsu_pkg::REG_FRICTION, 11'h7FF);  // upper bit dropped, friction 1023
    idle_on = 0;                                 // full-rate stretch
    random_requests(80);
    idle_on = 1;
    write_reg(bdsu_pkg::REG_REACTION, 11'd0);
    write_reg(bdsu_pkg::REG_FRICTION, 11'd0);    // never any braking
    random_requests(40);
    for (int ph = 0; ph < 3; ph++) begin
      write_reg(bdsu_pkg::REG_REACTION, 11'($urandom_range(102, 1024)));
      write_reg(bdsu_pkg::REG_FRICTION, 11'($urandom_range(102, 768)));
      random_requests(45);
    end

    s_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    $display("Covered %0d requests, %0d results checked (%0d without braking),",
             sent, sb.checked, sb.nobrake_seen);
    $display("across 8 register settings with random stalls and one long output hold.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("braking_distance_speed_unit_top verification clean");
    end else begin
      $display("braking_distance_speed_unit_top verification failed");
    end
    $finish;
  end
endmodule
